@@ design/card_frame_crc_checker_top_assert.svh @@
// Assertion macros for the card frame CRC checker.
// Each macro expects clk and rst to be visible where it is used.
`ifndef CARD_FRAME_CRC_CHECKER_TOP_ASSERT_SVH
`define CARD_FRAME_CRC_CHECKER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CFCC_ASSERT_SAME(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("cfcc assertion failed");
`define CFCC_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("cfcc assertion failed");
`else
`define CFCC_ASSERT_SAME(name, cond, prop)
`define CFCC_ASSERT_NEXT(name, cond, prop)
`endif
`endif

@@ design/cfcc_pkg.sv @@
package cfcc_pkg;

  localparam logic [7:0]  HEAD0    = 8'h55;
  localparam logic [7:0]  HEAD1    = 8'hAA;
  localparam logic [7:0]  TAIL0    = 8'hAA;
  localparam logic [7:0]  TAIL1    = 8'h55;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Byte positions within a frame.
  localparam logic [3:0] POS_HEAD0   = 4'd0;
  localparam logic [3:0] POS_HEAD1   = 4'd1;
  localparam logic [3:0] POS_ID0     = 4'd2;
  localparam logic [3:0] POS_ID1     = 4'd3;
  localparam logic [3:0] POS_ID2     = 4'd4;
  localparam logic [3:0] POS_ID3     = 4'd5;
  localparam logic [3:0] POS_CRC_HI  = 4'd6;
  localparam logic [3:0] POS_CRC_LO  = 4'd7;
  localparam logic [3:0] POS_TAIL0   = 4'd8;
  localparam logic [3:0] POS_TAIL1   = 4'd9;
  localparam logic [3:0] FRAME_LEN   = 4'd10;

  typedef struct packed {
    logic        done;
    logic [31:0] card_number;
    logic        frame_ok;
    logic [15:0] computed_crc;
  } frame_result_t;

  // CRC-16 with polynomial 0x1021, MSB first, one byte folded in.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

@@ design/cfcc_if.sv @@
interface cfcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       start_of_frame;

  modport source (output valid, output rx_byte, output start_of_frame, input ready);
  modport sink (input valid, input rx_byte, input start_of_frame, output ready);
endinterface

interface cfcc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] card_number;
  logic        frame_ok;
  logic [15:0] computed_crc;

  modport source (output valid, output card_number, output frame_ok, output computed_crc,
                  input ready);
  modport sink (input valid, input card_number, input frame_ok, input computed_crc,
                output ready);
endinterface

@@ design/cfcc_frame_core.sv @@
module cfcc_frame_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             rx_byte,
  input  logic                   start_of_frame,
  output cfcc_pkg::frame_result_t frame_result
);

  logic [3:0]  position;
  logic [15:0] crc;
  logic [31:0] id;
  logic        match;

  logic [3:0]  pos_eff;
  logic [15:0] crc_base;
  logic [31:0] id_base;
  logic        match_base;
  logic [15:0] crc_next;
  logic [31:0] id_next;
  logic        match_next;
  logic        done;

  always_comb begin
    pos_eff    = position;
    crc_base   = crc;
    id_base    = id;
    match_base = match;
    // A start flag, or a position that cannot normally arise, begins a fresh frame.
    if (start_of_frame || position >= cfcc_pkg::FRAME_LEN) begin
      pos_eff    = cfcc_pkg::POS_HEAD0;
      crc_base   = '0;
      id_base    = '0;
      match_base = 1'b1;
    end
    crc_next   = crc_base;
    id_next    = id_base;
    match_next = match_base;
    case (pos_eff)
      cfcc_pkg::POS_HEAD0: begin
        if (rx_byte != cfcc_pkg::HEAD0) match_next = 1'b0;
      end
      cfcc_pkg::POS_HEAD1: begin
        if (rx_byte != cfcc_pkg::HEAD1) match_next = 1'b0;
      end
      cfcc_pkg::POS_ID0, cfcc_pkg::POS_ID1, cfcc_pkg::POS_ID2, cfcc_pkg::POS_ID3: begin
        id_next  = {id_base[23:0], rx_byte};
        crc_next = cfcc_pkg::crc_byte(crc_base, rx_byte);
      end
      cfcc_pkg::POS_CRC_HI: begin
        if (rx_byte != crc_base[15:8]) match_next = 1'b0;
      end
      cfcc_pkg::POS_CRC_LO: begin
        if (rx_byte != crc_base[7:0]) match_next = 1'b0;
      end
      cfcc_pkg::POS_TAIL0: begin
        if (rx_byte != cfcc_pkg::TAIL0) match_next = 1'b0;
      end
      default: begin
        if (rx_byte != cfcc_pkg::TAIL1) match_next = 1'b0;
      end
    endcase
    done = (pos_eff == cfcc_pkg::POS_TAIL1);
  end

  assign frame_result.done         = done;
  assign frame_result.card_number  = id_base;
  assign frame_result.frame_ok     = match_next;
  assign frame_result.computed_crc = crc_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= cfcc_pkg::POS_HEAD0;
      crc      <= '0;
      id       <= '0;
      match    <= 1'b1;
    end else if (step) begin
      if (done) begin
        position <= cfcc_pkg::POS_HEAD0;
        crc      <= '0;
        id       <= '0;
        match    <= 1'b1;
      end else begin
        position <= 4'(pos_eff + 4'd1);
        crc      <= crc_next;
        id       <= id_next;
        match    <= match_next;
      end
    end
  end

endmodule

@@ design/card_frame_crc_checker_top.sv @@
// A byte is registered on acceptance and checked from that register; the frame result is
// loaded into the output register when the tenth byte moves on, and is offered from there.
// Throughput: one byte per cycle; a waiting result holds the tenth byte of the next frame.
// Reset (rst, synchronous, active high) empties both registers and starts a fresh frame.
module card_frame_crc_checker_top (
  input logic          clk,
  input logic          rst,
  cfcc_in_if.sink      byte_in,
  cfcc_out_if.source   result
);

  logic                    in_valid;
  logic [7:0]              in_byte;
  logic                    in_sof;
  logic                    out_valid;
  logic                    out_free;
  logic                    step;
  cfcc_pkg::frame_result_t frame_result;

  cfcc_frame_core u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .rx_byte        (in_byte),
    .start_of_frame (in_sof),
    .frame_result   (frame_result)
  );

  // A byte that finishes a frame may only move on when the result slot is free.
  assign out_free      = !out_valid || result.ready;
  assign step          = in_valid && (!frame_result.done || out_free);
  assign byte_in.ready = !in_valid || step;
  assign result.valid  = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.ready) begin
      in_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      in_byte <= byte_in.rx_byte;
      in_sof  <= byte_in.start_of_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && frame_result.done) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && frame_result.done) begin
      result.card_number  <= frame_result.card_number;
      result.frame_ok     <= frame_result.frame_ok;
      result.computed_crc <= frame_result.computed_crc;
    end
  end

`include "card_frame_crc_checker_top_assert.svh"

  `CFCC_ASSERT_NEXT(a_held_byte_kept, in_valid && !step, in_valid)
  `CFCC_ASSERT_NEXT(a_frame_end_gives_result, step && frame_result.done, out_valid)
  `CFCC_ASSERT_SAME(a_no_result_overwrite, out_valid && !result.ready, !(step && frame_result.done))

endmodule

@@ tb/card_frame_crc_checker_top_test.sv @@
module card_frame_crc_checker_top_test;

  localparam int DIRECTED_BYTES = 23;
  localparam int RANDOM_BYTES   = 1150;
  localparam int HOLD_OFF       = 300;
  localparam int CYCLE_LIMIT    = 200000;

  typedef struct {
    logic [31:0] card;
    logic        ok;
    logic [15:0] crc;
  } card_result_t;

  // Follows the frame state of the checker and keeps the results still owed by it.
  class card_frame_tracker;
    logic [3:0]   pos;
    logic [15:0]  crc;
    logic [31:0]  id;
    logic         ok;
    card_result_t awaited_cards[$];
    int           errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      pos = cfcc_pkg::POS_HEAD0;
      crc = '0;
      id  = '0;
      ok  = 1'b1;
    endfunction

    // Bit-serial form of the CRC: the feedback is the top CRC bit xored with the data bit.
    static function logic [15:0] fold_crc(logic [15:0] acc, logic [7:0] data);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb  = acc[15] ^ data[i];
        acc = {acc[14:0], 1'b0};
        if (fb) begin
          acc = acc ^ cfcc_pkg::CRC_POLY;
        end
      end
      return acc;
    endfunction

    function void take_byte(logic [7:0] b, logic sof);
      card_result_t r;
      if (sof || pos >= cfcc_pkg::FRAME_LEN) begin
        clear();
      end
      case (pos)
        cfcc_pkg::POS_HEAD0: begin
          if (b != cfcc_pkg::HEAD0) ok = 1'b0;
        end
        cfcc_pkg::POS_HEAD1: begin
          if (b != cfcc_pkg::HEAD1) ok = 1'b0;
        end
        cfcc_pkg::POS_ID0, cfcc_pkg::POS_ID1, cfcc_pkg::POS_ID2, cfcc_pkg::POS_ID3: begin
          id  = {id[23:0], b};
          crc = fold_crc(crc, b);
        end
        cfcc_pkg::POS_CRC_HI: begin
          if (b != crc[15:8]) ok = 1'b0;
        end
        cfcc_pkg::POS_CRC_LO: begin
          if (b != crc[7:0]) ok = 1'b0;
        end
        cfcc_pkg::POS_TAIL0: begin
          if (b != cfcc_pkg::TAIL0) ok = 1'b0;
        end
        default: begin
          if (b != cfcc_pkg::TAIL1) ok = 1'b0;
        end
      endcase
      if (pos == cfcc_pkg::POS_TAIL1) begin
        r.card = id;
        r.ok   = ok;
        r.crc  = crc;
        awaited_cards.push_back(r);
        clear();
      end else begin
        pos = pos + 4'd1;
      end
    endfunction

    function void match_result(logic [31:0] card, logic ok_seen, logic [15:0] crc_seen);
      card_result_t r;
      if (awaited_cards.size() == 0) begin
        $error("unexpected result: card_number %h, frame_ok %b, computed_crc %h",
               card, ok_seen, crc_seen);
        errors++;
        return;
      end
      r = awaited_cards.pop_front();
      if (card !== r.card) begin
        $error("card_number: expected %h, actual %h", r.card, card);
        errors++;
      end
      if (ok_seen !== r.ok) begin
        $error("frame_ok: expected %b, actual %b", r.ok, ok_seen);
        errors++;
      end
      if (crc_seen !== r.crc) begin
        $error("computed_crc: expected %h, actual %h", r.crc, crc_seen);
        errors++;
      end
    endfunction

    function int pending();
      return awaited_cards.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  cfcc_in_if  rx_bus();
  cfcc_out_if card_bus();

  card_frame_crc_checker_top dut (
    .clk    (clk),
    .rst    (rst),
    .byte_in(rx_bus),
    .result (card_bus)
  );

  card_frame_tracker tracker = new();

  int idle_pct     = 0;
  int stall_pct    = 0;
  bit hold_request = 1'b0;
  int bytes_sent   = 0;
  int cycles       = 0;

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, and one long hold-off on request.
  initial begin
    card_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        card_bus.ready <= 1'b0;
        for (int n = 0; n < HOLD_OFF; n++) begin
          @(posedge clk);
        end
        hold_request = 1'b0;
      end else begin
        card_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && card_bus.valid && card_bus.ready) begin
      tracker.match_result(card_bus.card_number, card_bus.frame_ok, card_bus.computed_crc);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic sof);
    while ($urandom_range(99) < idle_pct) begin
      rx_bus.valid <= 1'b0;
      @(posedge clk);
    end
    rx_bus.valid          <= 1'b1;
    rx_bus.rx_byte        <= b;
    rx_bus.start_of_frame <= sof;
    do begin
      @(posedge clk);
    end while (!rx_bus.ready);
    tracker.take_byte(b, sof);
    bytes_sent++;
  endtask

  // Sends the first len bytes of a frame for the given ID; bad_at names a byte to spoil.
  task automatic send_frame(input logic [31:0] id, input logic first_sof, input int bad_at,
                            input int len);
    logic [7:0]  fb [10];
    logic [15:0] c;
    fb[0] = cfcc_pkg::HEAD0;
    fb[1] = cfcc_pkg::HEAD1;
    c = '0;
    for (int i = 0; i < 4; i++) begin
      fb[2 + i] = id[31 - 8 * i -: 8];
      c = card_frame_tracker::fold_crc(c, fb[2 + i]);
    end
    fb[6] = c[15:8];
    fb[7] = c[7:0];
    fb[8] = cfcc_pkg::TAIL0;
    fb[9] = cfcc_pkg::TAIL1;
    if (bad_at >= 0) begin
      fb[bad_at] = fb[bad_at] ^ 8'($urandom_range(255, 1));
    end
    for (int i = 0; i < len; i++) begin
      send_byte(fb[i], (i == 0) ? first_sof : 1'b0);
    end
  endtask

  task automatic pause_until_drained();
    rx_bus.valid <= 1'b0;
    while (tracker.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    bit aligned;
    int phase;
    int last_phase;
    int pick;
    int n;

    rst                   <= 1'b1;
    rx_bus.valid          <= 1'b0;
    rx_bus.rx_byte        <= 8'h00;
    rx_bus.start_of_frame <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // A clean frame with an all-ones ID, a frame cut short after its header and first ID byte
    // by a fresh start flag, then an all-zero ID with a spoilt closing byte.
    send_frame(32'hFFFF_FFFF, 1'b1, -1, 10);
    send_frame(32'h1234_5678, 1'b1, -1, 3);
    send_frame(32'h0000_0000, 1'b1, 9, 10);
    aligned    = 1'b1;
    last_phase = -1;

    while (bytes_sent < DIRECTED_BYTES + RANDOM_BYTES) begin
      phase = (bytes_sent - DIRECTED_BYTES) * 4 / RANDOM_BYTES;
      if (phase > 3) phase = 3;
      if (phase != last_phase) begin
        case (phase)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 59; stall_pct = 0;  hold_request = 1'b1; end
          2: begin idle_pct = 0;  stall_pct = 59; end
          default: begin
            pause_until_drained();
            idle_pct  = 22;
            stall_pct = 22;
          end
        endcase
        last_phase = phase;
      end

      pick = $urandom_range(99);
      if (pick < 75) begin
        send_frame($urandom(), aligned ? 1'($urandom_range(1)) : 1'b1,
                   ($urandom_range(99) < 30) ? int'($urandom_range(9)) : -1, 10);
        aligned = 1'b1;
      end else if (pick < 87) begin
        send_frame($urandom(), 1'b1, -1, $urandom_range(9, 1));
        aligned = 1'b0;
      end else begin
        n = $urandom_range(5, 1);
        for (int i = 0; i < n; i++) begin
          send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        aligned = 1'b0;
      end
    end

    pause_until_drained();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
